// File: hdl/crlf_pkg.sv
// Shared constants, command codes and character helpers for the CR LF line receiver.
package crlf_pkg;

    localparam int LINE_MAX_DEFAULT = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] CMD_STORE = 2'd0;
    localparam logic [KIND_W-1:0] CMD_ERROR = 2'd1;
    localparam logic [KIND_W-1:0] CMD_EMIT = 2'd2;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_M = 8'h6d;
    localparam logic [7:0] CH_U = 8'h75;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_kept(input logic [7:0] c);
        return ((c >= CH_SPACE) && (c <= CH_TILDE)) || (c == CH_TAB);
    endfunction

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
        begin
            return c + CH_CASE_OFS;
        end
        return c;
    endfunction

endpackage

// File: hdl/crlf_front.sv
// Front end: byte classification, line framing, trim bounds and route detection.
module crlf_front
    import crlf_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  logic [7:0]                  rx_byte,
    input  logic                        queue_full,
    output logic                        cmd_push,
    output logic [KIND_W-1:0]           cmd_kind,
    output logic [7:0]                  cmd_char,
    output logic [$clog2(LINE_MAX)-1:0] cmd_lo,
    output logic [$clog2(LINE_MAX)-1:0] cmd_hi,
    output logic                        cmd_route
);

    localparam int CAPACITY = LINE_MAX - 1;
    localparam int CNT_W = $clog2(LINE_MAX);

    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic             ovf_reg, ovf_next;
    logic             inv_reg, inv_next;
    logic             cr_reg, cr_next;
    logic             seen_reg, seen_next;
    logic             tok_done_reg, tok_done_next;
    logic [1:0]       tok_cnt_reg, tok_cnt_next;
    logic             match_reg, match_next;
    logic             accept;
    logic             clear_line;
    logic [7:0]       low_char;

    assign rx_stall = queue_full;
    assign accept = rx_valid && !queue_full;
    assign low_char = lower_of(rx_byte);

    always_comb
    begin
        len_next = len_reg;
        first_next = first_reg;
        end_next = end_reg;
        ovf_next = ovf_reg;
        inv_next = inv_reg;
        cr_next = cr_reg;
        seen_next = seen_reg;
        tok_done_next = tok_done_reg;
        tok_cnt_next = tok_cnt_reg;
        match_next = match_reg;
        clear_line = 1'b0;
        cmd_push = 1'b0;
        cmd_kind = CMD_STORE;
        cmd_char = rx_byte;
        cmd_lo = len_reg;
        cmd_hi = end_reg;
        cmd_route = seen_reg && match_reg && (tok_cnt_reg == 2'd3);
        if (accept)
        begin
            priority if (cr_reg)
            begin
                clear_line = 1'b1;
                if (rx_byte == CH_LF)
                begin
                    if (ovf_reg || inv_reg)
                    begin
                        cmd_push = 1'b1;
                        cmd_kind = CMD_ERROR;
                    end
                    else if (seen_reg)
                    begin
                        cmd_push = 1'b1;
                        cmd_kind = CMD_EMIT;
                        cmd_lo = first_reg;
                    end
                end
                else
                begin
                    cmd_push = 1'b1;
                    cmd_kind = CMD_ERROR;
                end
            end
            else if (rx_byte == CH_LF)
            begin
                clear_line = 1'b1;
                cmd_push = 1'b1;
                cmd_kind = CMD_ERROR;
            end
            else if (rx_byte == CH_CR)
            begin
                cr_next = 1'b1;
            end
            else if (!is_kept(rx_byte))
            begin
                inv_next = 1'b1;
            end
            else if (ovf_reg)
            begin
                ovf_next = 1'b1;
            end
            else if (len_reg >= CNT_W'(CAPACITY))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cmd_push = 1'b1;
                cmd_kind = CMD_STORE;
                len_next = len_reg + CNT_W'(1);
                if (!is_blank(rx_byte))
                begin
                    end_next = len_reg + CNT_W'(1);
                end
                if (!seen_reg)
                begin
                    if (!is_blank(rx_byte))
                    begin
                        seen_next = 1'b1;
                        first_next = len_reg;
                        tok_cnt_next = 2'd1;
                        match_next = (low_char == CH_I);
                    end
                end
                else if (!tok_done_reg)
                begin
                    if (is_blank(rx_byte))
                    begin
                        tok_done_next = 1'b1;
                    end
                    else if (tok_cnt_reg == 2'd1)
                    begin
                        tok_cnt_next = 2'd2;
                        match_next = match_reg && (low_char == CH_M);
                    end
                    else if (tok_cnt_reg == 2'd2)
                    begin
                        tok_cnt_next = 2'd3;
                        match_next = match_reg && (low_char == CH_U);
                    end
                    else
                    begin
                        match_next = 1'b0;
                    end
                end
            end
            if (clear_line)
            begin
                len_next = '0;
                first_next = '0;
                end_next = '0;
                ovf_next = 1'b0;
                inv_next = 1'b0;
                cr_next = 1'b0;
                seen_next = 1'b0;
                tok_done_next = 1'b0;
                tok_cnt_next = 2'd0;
                match_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            first_reg <= '0;
            end_reg <= '0;
            ovf_reg <= 1'b0;
            inv_reg <= 1'b0;
            cr_reg <= 1'b0;
            seen_reg <= 1'b0;
            tok_done_reg <= 1'b0;
            tok_cnt_reg <= 2'd0;
            match_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            first_reg <= first_next;
            end_reg <= end_next;
            ovf_reg <= ovf_next;
            inv_reg <= inv_next;
            cr_reg <= cr_next;
            seen_reg <= seen_next;
            tok_done_reg <= tok_done_next;
            tok_cnt_reg <= tok_cnt_next;
            match_reg <= match_next;
        end
    end

endmodule

// File: hdl/crlf_cmd_fifo.sv
// Command queue between the front end and the line store back end.
module crlf_cmd_fifo
    import crlf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/crlf_back.sv
// Back end: line store, command execution and registered result output.
module crlf_back
    import crlf_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic [KIND_W-1:0]           cmd_kind,
    input  logic [7:0]                  cmd_char,
    input  logic [$clog2(LINE_MAX)-1:0] cmd_lo,
    input  logic [$clog2(LINE_MAX)-1:0] cmd_hi,
    input  logic                        cmd_route,
    output logic                        cmd_pop,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        event_res,
    output logic [7:0]                  line_char,
    output logic                        route_imu,
    output logic                        last
);

    localparam int CAPACITY = LINE_MAX - 1;
    localparam int CNT_W = $clog2(LINE_MAX);
    localparam int ADDR_W = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [7:0]       line_mem [CAPACITY];
    logic [7:0]       rd_data_reg;
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic             route_reg, route_next;
    logic             res_valid_reg, res_valid_next;
    logic             event_reg;
    logic [7:0]       char_reg;
    logic             route_out_reg;
    logic             last_reg;
    logic             out_free;
    logic             mem_we;
    logic             mem_re;
    logic             load;
    logic             load_event;
    logic [7:0]       load_char;
    logic             load_route;
    logic             load_last;
    logic             at_end;

    assign out_free = !res_valid_reg || !res_stall;
    assign at_end = ((rd_ptr_reg + CNT_W'(1)) == end_reg);

    always_comb
    begin
        state_next = state_reg;
        rd_ptr_next = rd_ptr_reg;
        end_next = end_reg;
        route_next = route_reg;
        cmd_pop = 1'b0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        load = 1'b0;
        load_event = 1'b0;
        load_char = rd_data_reg;
        load_route = route_reg;
        load_last = at_end;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_kind)
                        CMD_STORE:
                        begin
                            mem_we = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_ERROR:
                        begin
                            if (out_free)
                            begin
                                load = 1'b1;
                                load_event = 1'b1;
                                load_char = '0;
                                load_route = 1'b0;
                                load_last = 1'b1;
                                cmd_pop = 1'b1;
                            end
                        end
                        CMD_EMIT:
                        begin
                            cmd_pop = 1'b1;
                            rd_ptr_next = cmd_lo;
                            end_next = cmd_hi;
                            route_next = cmd_route;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rd_ptr_reg <= '0;
            end_reg <= '0;
            route_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            end_reg <= end_next;
            route_reg <= route_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= load_event;
            char_reg <= load_char;
            route_out_reg <= load_route;
            last_reg <= load_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[cmd_lo[ADDR_W-1:0]] <= cmd_char;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    assign res_valid = res_valid_reg;
    assign event_res = event_reg;
    assign line_char = char_reg;
    assign route_imu = route_out_reg;
    assign last = last_reg;

endmodule

// File: hdl/crlf_command_line_receiver.sv
// CR LF command line receiver top level: front end, command queue and line store back end.
// Bytes are taken one per cycle while the command queue has room; the back end writes each
// kept byte into the single-port line store.
// After the closing LF, each character passes the registered line store read, then the output
// register, and the output can stall it; an error goes straight to the output register.
// rst_n clears all control state at once; the line store is not cleared and needs no pass.
module crlf_command_line_receiver
    import crlf_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       event_res,
    output logic [7:0] line_char,
    output logic       route_imu,
    output logic       last
);

    localparam int CNT_W = $clog2(LINE_MAX);
    localparam int CMD_W = KIND_W + 8 + 2 * CNT_W + 1;

    logic              cmd_push;
    logic [KIND_W-1:0] push_kind;
    logic [7:0]        push_char;
    logic [CNT_W-1:0]  push_lo;
    logic [CNT_W-1:0]  push_hi;
    logic              push_route;
    logic [CMD_W-1:0]  push_data;
    logic [CMD_W-1:0]  head_data;
    logic              cmd_pop;
    logic              cmd_full;
    logic              cmd_empty;

    crlf_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .queue_full (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_kind   (push_kind),
        .cmd_char   (push_char),
        .cmd_lo     (push_lo),
        .cmd_hi     (push_hi),
        .cmd_route  (push_route)
    );

    assign push_data = {push_kind, push_char, push_lo, push_hi, push_route};

    crlf_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (push_data),
        .pop   (cmd_pop),
        .rdata (head_data),
        .full  (cmd_full),
        .empty (cmd_empty)
    );

    crlf_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_kind  (head_data[CMD_W-1 -: KIND_W]),
        .cmd_char  (head_data[CMD_W-KIND_W-1 -: 8]),
        .cmd_lo    (head_data[2*CNT_W : CNT_W+1]),
        .cmd_hi    (head_data[CNT_W : 1]),
        .cmd_route (head_data[0]),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .event_res (event_res),
        .line_char (line_char),
        .route_imu (route_imu),
        .last      (last)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("request pushed into a full command queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from an empty queue");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && event_res) |-> (line_char == 8'd0 && !route_imu && last))
        else $error("format error request carries line data");
`endif

endmodule
